// ===== hw/rtl/csn_pkg.sv =====
// Package with types, constants and the exponential table for the softmax normalizer.
`default_nettype none
package csn_pkg;
   localparam int MaxValues = 64;
   localparam int IdxW = 6;
   localparam int CntW = 7;
   localparam int ExpW = 32;
   localparam int SumW = 38;

   typedef enum logic [1:0] {
      CSR_BETA = 2'd0,
      CSR_CEIL = 2'd1,
      CSR_FLOOR = 2'd2
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCALE = 6'b000010,
      ST_EXP   = 6'b000100,
      ST_READ  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic [15:0] sample_value;
      logic        final_value;
   } req_type;

   typedef struct packed {
      logic [16:0] probability;
      logic [5:0]  entry_index;
      logic        final_result;
   } rsp_type;

   // exp(f/256) for f in 0..255, as Q2.30, rounded.
   function automatic logic [31:0] exp_frac(input logic [7:0] f);
      real v;
      v = $exp(real'(f) / 256.0) * 1073741824.0 + 0.5;
      return 32'(longint'(v));
   endfunction

   // exp(i) for integer part i in -16..15, as Q24.40.
   function automatic logic [63:0] exp_int(input logic signed [4:0] i);
      real v;
      v = $exp(real'(i)) * 1099511627776.0;
      return 64'(longint'(v / 256.0)) << 8;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/csn_if.sv =====
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface csn_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/clamped_softmax_normalizer.sv =====
// Top level of the clamped softmax normalizer.
// Beats on req carry one Q8.8 value and a last flag. Each value is scaled by
// beta, clamped, turned into a Q17.15 exponential and stored in the ST_SCALE
// and ST_EXP states after its beat, while req is not ready; a new value is
// taken only once the last is stored. The exponential uses one 32 by 32
// multiplier twice. When the last value (or the sixty-fourth) arrives, the
// block emits one rsp beat per stored value with the probability, its index
// and a last flag. Each probability comes from a shared restoring divider
// that takes one quotient bit per cycle; each entry is read, divided and
// loaded into the result register in turn. The result register holds each
// beat until taken; while rsp stalls the block waits and accepts nothing
// until the last beat is loaded. Reset clears the set and restores the
// control and configuration registers to defaults; the store itself is not
// cleared since only entries of the current set are read. Configuration
// must be written through csr_ while idle; the block does not enforce it.
`default_nettype none
module clamped_softmax_normalizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   csn_if.sink              req,
   csn_if.source            rsp
);
   csn_pkg::state_type state_ff, state_in;
   logic signed [15:0] beta_ff;
   logic [11:0] ceil_ff;
   logic signed [12:0] floor_ff;
   logic [csn_pkg::CntW-1:0] count_ff, count_in;
   logic [csn_pkg::IdxW-1:0] ptr_ff, ptr_in;
   logic [csn_pkg::SumW-1:0] sum_ff, sum_in;
   logic last_ff, last_in;
   logic signed [31:0] prod_ff, prod_in;
   logic [31:0] exp_in;
   logic [31:0] mem [csn_pkg::MaxValues];
   logic [31:0] rd_ff;
   logic [49:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [4:0] bit_ff, bit_in;
   logic [63:0] lo_ff, lo_in;
   csn_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic wr_en;

   logic signed [19:0] arg_raw;
   logic signed [12:0] arg;
   logic signed [4:0] ai;
   logic [63:0] big;
   logic [31:0] frac;
   logic [31:0] mul_a;
   logic [63:0] mul_p;
   logic [95:0] full;
   logic shift_in;
   logic [50:0] trial;
   logic [csn_pkg::CntW-1:0] cnt_next;

   always_comb begin
      arg_raw = 20'(prod_ff >>> 12);
      if (arg_raw > $signed({8'd0, ceil_ff})) arg = $signed({1'b0, ceil_ff});
      else if (arg_raw < $signed({{7{floor_ff[12]}}, floor_ff})) arg = floor_ff;
      else arg = 13'(arg_raw);
      ai = 5'(arg >>> 8);
      big = csn_pkg::exp_int(ai);
      frac = csn_pkg::exp_frac(arg[7:0]);
      mul_a = (state_ff == csn_pkg::ST_SCALE) ? big[31:0] : big[63:32];
      mul_p = mul_a * frac;
      full = {mul_p, 32'd0} + {32'd0, lo_ff};
   end

   always_comb begin
      logic [63:0] r;
      r = 64'(full >> 54) + 64'd1;
      r = r >> 1;
      if (r > 64'hFFFF_FFFF) exp_in = 32'hFFFF_FFFF;
      else if (r == 0) exp_in = 32'd1;
      else exp_in = r[31:0];
   end

   assign shift_in = (bit_ff == 5'd1) & rd_ff[0];
   assign trial = {rem_ff, shift_in} - {13'd0, sum_ff};
   assign cnt_next = count_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      sum_in = sum_ff;
      last_in = last_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      bit_in = bit_ff;
      lo_in = lo_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      wr_en = 1'b0;
      if (rsp.ready) out_valid_in = 1'b0;
      case (state_ff)
         csn_pkg::ST_IDLE: begin
            if (req.valid) begin
               prod_in = $signed(req.payload.sample_value) * beta_ff;
               last_in = req.payload.final_value;
               state_in = csn_pkg::ST_SCALE;
            end
         end
         csn_pkg::ST_SCALE: begin
            lo_in = mul_p;
            state_in = csn_pkg::ST_EXP;
         end
         csn_pkg::ST_EXP: begin
            wr_en = 1'b1;
            sum_in = sum_ff + {6'd0, exp_in};
            count_in = cnt_next;
            ptr_in = 6'd0;
            if (last_ff || cnt_next == 7'(csn_pkg::MaxValues)) state_in = csn_pkg::ST_READ;
            else state_in = csn_pkg::ST_IDLE;
         end
         csn_pkg::ST_READ: begin
            quo_in = 17'd0;
            bit_in = 5'd0;
            state_in = csn_pkg::ST_DIV;
         end
         csn_pkg::ST_DIV: begin
            // Dividend is entry << 16; its bits are fed one per cycle.
            if (bit_ff == 5'd0) rem_in = 50'(rd_ff >> 1);
            else if (!trial[50]) begin
               rem_in = trial[49:0];
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = {rem_ff[48:0], shift_in};
               quo_in = {quo_ff[15:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 5'd17) state_in = csn_pkg::ST_OUT;
         end
         csn_pkg::ST_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_in.probability = quo_ff;
               out_in.entry_index = ptr_ff;
               out_in.final_result = (7'(ptr_ff) + 1'b1 == count_ff);
               if (7'(ptr_ff) + 1'b1 == count_ff) begin
                  count_in = '0;
                  sum_in = '0;
                  state_in = csn_pkg::ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
                  state_in = csn_pkg::ST_READ;
               end
            end
         end
         default: state_in = csn_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[count_ff[csn_pkg::IdxW-1:0]] <= exp_in;
      rd_ff <= mem[ptr_in];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      lo_ff <= lo_in;
      out_ff <= out_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff <= csn_pkg::ST_IDLE;
         count_ff <= '0;
         ptr_ff <= '0;
         sum_ff <= '0;
         bit_ff <= '0;
         out_valid_ff <= 1'b0;
         beta_ff <= 16'sd4096;
         ceil_ff <= 12'd2560;
         floor_ff <= -13'sd2816;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff <= ptr_in;
         sum_ff <= sum_in;
         bit_ff <= bit_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            case (csr_index)
               csn_pkg::CSR_BETA: beta_ff <= csr_data;
               csn_pkg::CSR_CEIL: ceil_ff <= csr_data[11:0];
               csn_pkg::CSR_FLOOR: floor_ff <= csr_data[12:0];
               default: ;
            endcase
         end
      end
   end

   assign req.ready = (state_ff == csn_pkg::ST_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule
`default_nettype wire
